// File: hdl/ps2_keyboard_mouse_controller_macros.svh
// ----------------------------------------------------------------------------
// ps2_keyboard_mouse_controller_macros
// Assertion helpers shared by the rtl files.
// ----------------------------------------------------------------------------
`ifndef PS2_KEYBOARD_MOUSE_CONTROLLER_MACROS_SVH
`define PS2_KEYBOARD_MOUSE_CONTROLLER_MACROS_SVH

// condition must hold in the same cycle
`define PS2KMC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition must hold in the next cycle
`define PS2KMC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/ps2kmc_pkg.sv
// ----------------------------------------------------------------------------
// ps2kmc_pkg
// Shared types, codes and helpers of the ps/2 keyboard and mouse controller.
// ----------------------------------------------------------------------------
`default_nettype none

package ps2kmc_pkg;

    localparam int FIFO_DEPTH_DEF = 256;
    localparam int ACC_WIDTH_DEF  = 16;

    // port functions
    localparam logic [2:0] FN_DATA_RD = 3'd0;
    localparam logic [2:0] FN_STAT_RD = 3'd1;
    localparam logic [2:0] FN_DATA_WR = 3'd2;
    localparam logic [2:0] FN_CMD_WR  = 3'd3;
    localparam logic [2:0] FN_EVENT   = 3'd4;

    // reply bytes
    localparam logic [7:0] B_ACK      = 8'hFA;
    localparam logic [7:0] B_RESEND   = 8'hFE;
    localparam logic [7:0] B_ID0      = 8'hAB;
    localparam logic [7:0] B_ID1_XLAT = 8'h41;
    localparam logic [7:0] B_ID1      = 8'h83;
    localparam logic [7:0] B_BAT_OK   = 8'hAA;
    localparam logic [7:0] B_SELFTEST = 8'h55;
    localparam logic [7:0] B_SET1     = 8'h43;
    localparam logic [7:0] B_SET2     = 8'h02;
    localparam logic [7:0] B_SET3     = 8'h27;
    localparam logic [7:0] B_SET3_X   = 8'h3F;

    // controller commands
    localparam logic [7:0] CC_RD_MODE  = 8'h20;
    localparam logic [7:0] CC_WR_MODE  = 8'h60;
    localparam logic [7:0] CC_AUX_DIS  = 8'hA7;
    localparam logic [7:0] CC_AUX_EN   = 8'hA8;
    localparam logic [7:0] CC_AUX_TEST = 8'hA9;
    localparam logic [7:0] CC_SELFTEST = 8'hAA;
    localparam logic [7:0] CC_KBD_TEST = 8'hAB;
    localparam logic [7:0] CC_KBD_DIS  = 8'hAD;
    localparam logic [7:0] CC_KBD_EN   = 8'hAE;
    localparam logic [7:0] CC_RD_IN    = 8'hC0;
    localparam logic [7:0] CC_RD_OUT   = 8'hD0;
    localparam logic [7:0] CC_WR_OUT   = 8'hD1;
    localparam logic [7:0] CC_WR_KOBUF = 8'hD2;
    localparam logic [7:0] CC_WR_AOBUF = 8'hD3;
    localparam logic [7:0] CC_WR_AUX   = 8'hD4;
    localparam logic [7:0] CC_A20_OFF  = 8'hDD;
    localparam logic [7:0] CC_A20_ON   = 8'hDF;
    localparam logic [7:0] CC_NONE     = 8'h00;

    // keyboard commands
    localparam logic [7:0] KC_BAD     = 8'h05;
    localparam logic [7:0] KC_LEDS    = 8'hED;
    localparam logic [7:0] KC_ECHO    = 8'hEE;
    localparam logic [7:0] KC_SCANSET = 8'hF0;
    localparam logic [7:0] KC_ID      = 8'hF2;
    localparam logic [7:0] KC_RATE    = 8'hF3;
    localparam logic [7:0] KC_ENABLE  = 8'hF4;
    localparam logic [7:0] KC_DISABLE = 8'hF5;
    localparam logic [7:0] KC_DEFAULT = 8'hF6;
    localparam logic [7:0] KC_RESET   = 8'hFF;

    // mouse commands
    localparam logic [7:0] MC_SCALE1  = 8'hE6;
    localparam logic [7:0] MC_SCALE2  = 8'hE7;
    localparam logic [7:0] MC_SETRES  = 8'hE8;
    localparam logic [7:0] MC_STATUS  = 8'hE9;
    localparam logic [7:0] MC_STREAM  = 8'hEA;
    localparam logic [7:0] MC_READ    = 8'hEB;
    localparam logic [7:0] MC_WRAPOFF = 8'hEC;
    localparam logic [7:0] MC_WRAPON  = 8'hEE;
    localparam logic [7:0] MC_REMOTE  = 8'hF0;
    localparam logic [7:0] MC_ID      = 8'hF2;
    localparam logic [7:0] MC_RATE    = 8'hF3;
    localparam logic [7:0] MC_ENABLE  = 8'hF4;
    localparam logic [7:0] MC_DISABLE = 8'hF5;
    localparam logic [7:0] MC_DEFAULT = 8'hF6;
    localparam logic [7:0] MC_RESET   = 8'hFF;

    localparam logic [7:0] RATE_200 = 8'd200;
    localparam logic [7:0] RATE_100 = 8'd100;
    localparam logic [7:0] RATE_80  = 8'd80;

    // sub-state codes
    localparam logic [1:0] KX_IDLE = 2'd0;
    localparam logic [1:0] KX_SET  = 2'd1;
    localparam logic [1:0] KX_LEDS = 2'd2;
    localparam logic [1:0] KX_RATE = 2'd3;
    localparam logic [1:0] AX_IDLE = 2'd0;
    localparam logic [1:0] AX_RES  = 2'd1;
    localparam logic [1:0] AX_RATE = 2'd2;
    localparam logic [1:0] DT_IDLE = 2'd0;
    localparam logic [1:0] DT_200  = 2'd1;
    localparam logic [1:0] DT_100  = 2'd2;
    localparam logic [1:0] DT_2002 = 2'd3;
    localparam logic [2:0] KIND_STD   = 3'd0;
    localparam logic [2:0] KIND_WHEEL = 3'd3;
    localparam logic [2:0] KIND_5BTN  = 3'd4;
    localparam logic [1:0] PEND_AUX   = 2'd2;

    typedef enum logic [2:0] {
        OP_RD, OP_STAT, OP_WR, OP_CMD, OP_EVT, OP_NOP
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [7:0]         wdata;
        logic signed [11:0] mx;
        logic signed [11:0] my;
        logic signed [11:0] mz;
        logic [2:0]         btn;   // bit0 left, bit1 right, bit2 middle
    } item_t;

    typedef struct packed {
        logic [7:0] rdata;
        logic       kbd_irq;
        logic       aux_irq;
        logic       a20;
    } res_t;

    typedef struct packed {
        logic       push;
        logic       pop;
        logic [7:0] data;
    } fifo_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_RD_WAIT, ST_EMIT, ST_CHK, ST_PKT, ST_POST, ST_DONE
    } state_t;

    function automatic op_t classify(input logic [2:0] fn);
        op_t o;
        unique case (fn)
            FN_DATA_RD: o = OP_RD;
            FN_STAT_RD: o = OP_STAT;
            FN_DATA_WR: o = OP_WR;
            FN_CMD_WR:  o = OP_CMD;
            FN_EVENT:   o = OP_EVT;
            default:    o = OP_NOP;
        endcase
        return o;
    endfunction

    // output port bits 4 and 5 follow the pending flags
    function automatic logic [7:0] refresh_port(input logic [7:0] port,
                                                input logic [1:0] pend);
        logic [7:0] p;
        p    = port;
        p[4] = (pend != 2'd0);
        p[5] = (pend == PEND_AUX);
        return p;
    endfunction

endpackage

`default_nettype wire

// File: hdl/ps2kmc_front.sv
// ----------------------------------------------------------------------------
// ps2kmc_front
// Two-entry input queue that takes port beats and classifies the function.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2kmc_front
    import ps2kmc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [2:0]  func,
    input  wire logic [7:0]  wdata,
    input  wire logic [11:0] move_x,
    input  wire logic [11:0] move_y,
    input  wire logic [11:0] move_z,
    input  wire logic        btn_left,
    input  wire logic        btn_middle,
    input  wire logic        btn_right,
    output item_t            head,
    output logic             head_valid,
    input  wire logic        head_take
);

    item_t      q0_reg, q0_next, q1_reg, q1_next, in_item;
    logic [1:0] cnt_reg, cnt_next, pos;
    logic       acc;

    assign full       = (cnt_reg == 2'd2);
    assign head       = q0_reg;
    assign head_valid = (cnt_reg != 2'd0);
    assign acc        = push && !full;

    always_comb
    begin
        in_item.op    = classify(func);
        in_item.wdata = wdata;
        in_item.mx    = $signed(move_x);
        in_item.my    = $signed(move_y);
        in_item.mz    = $signed(move_z);
        in_item.btn   = {btn_middle, btn_right, btn_left};
    end

    always_comb
    begin
        q0_next  = q0_reg;
        q1_next  = q1_reg;
        pos      = cnt_reg;
        if (head_take && head_valid)
        begin
            q0_next = q1_reg;
            pos     = cnt_reg - 2'd1;
        end
        cnt_next = pos;
        if (acc)
        begin
            if (pos == 2'd0)
                q0_next = in_item;
            else
                q1_next = in_item;
            cnt_next = pos + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        q0_reg <= q0_next;
        q1_reg <= q1_next;
    end

endmodule

`default_nettype wire

// File: hdl/ps2kmc_fifo.sv
// ----------------------------------------------------------------------------
// ps2kmc_fifo
// Reply byte queue; a read of an empty queue returns the previous byte.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ps2_keyboard_mouse_controller_macros.svh"

module ps2kmc_fifo
    import ps2kmc_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF,
    localparam int PW = $clog2(FIFO_DEPTH),
    localparam int CW = $clog2(FIFO_DEPTH + 1)
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire fifo_ctl_t   ctl,
    output logic [7:0]       rdata,
    output logic [CW-1:0]    count
);

    localparam logic [PW-1:0] LAST = PW'(FIFO_DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(FIFO_DEPTH);

    logic [7:0]    mem [FIFO_DEPTH];
    logic [7:0]    rdata_reg;
    logic [PW-1:0] rd_reg, wr_reg, raddr;
    logic [CW-1:0] count_reg;
    logic          do_push, do_pop;

    assign rdata   = rdata_reg;
    assign count   = count_reg;
    assign do_push = ctl.push && (count_reg != FULL);
    assign do_pop  = ctl.pop && (count_reg != '0);

    always_comb
    begin
        if (count_reg != '0)
            raddr = rd_reg;
        else if (rd_reg == '0)
            raddr = LAST;
        else
            raddr = rd_reg - PW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_reg] <= ctl.data;
        if (ctl.pop)
            rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg    <= '0;
            wr_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
                wr_reg <= (wr_reg == LAST) ? '0 : wr_reg + PW'(1);
            if (do_pop)
                rd_reg <= (rd_reg == LAST) ? '0 : rd_reg + PW'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + CW'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - CW'(1);
        end
    end

    `PS2KMC_ASSERT_NOW(a_cnt_bound, clk, rst_n, 1'b1, count_reg <= FULL, "fifo count overflow")
    `PS2KMC_ASSERT_NEXT(a_full_drop, clk, rst_n, ctl.push && !ctl.pop && count_reg == FULL, count_reg == FULL, "push into full fifo changed count")
    `PS2KMC_ASSERT_NEXT(a_empty_rd, clk, rst_n, ctl.pop && !ctl.push && count_reg == '0, count_reg == '0 && $stable(rd_reg), "empty read moved pointer")

endmodule

`default_nettype wire

// File: hdl/ps2kmc_engine.sv
// ----------------------------------------------------------------------------
// ps2kmc_engine
// Back end: executes port accesses, answers device commands byte by byte and
// streams mouse packets into the reply queues.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ps2_keyboard_mouse_controller_macros.svh"

module ps2kmc_engine
    import ps2kmc_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF,
    parameter int ACC_WIDTH  = ACC_WIDTH_DEF,
    localparam int CW = $clog2(FIFO_DEPTH + 1)
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire item_t head,
    input  wire logic  head_valid,
    output logic       head_take,
    output res_t       res,
    output logic       res_valid,
    input  wire logic  res_pop
);

    typedef logic signed [ACC_WIDTH-1:0] acc_t;

    localparam acc_t LIM_P  = acc_t'(127);
    localparam acc_t LIM_Z  = acc_t'(7);
    localparam logic [CW-1:0] CNT_FULL = CW'(FIFO_DEPTH);
    localparam logic [CW-1:0] CNT_HIGH = CW'(FIFO_DEPTH - 16);

    function automatic acc_t sat_add(input acc_t a, input logic signed [11:0] d,
                                     input logic neg);
        logic signed [ACC_WIDTH:0] s;
        logic signed [ACC_WIDTH:0] de;
        de = (ACC_WIDTH+1)'(d);
        s  = neg ? ((ACC_WIDTH+1)'(a) - de) : ((ACC_WIDTH+1)'(a) + de);
        if (s[ACC_WIDTH] != s[ACC_WIDTH-1])
            return s[ACC_WIDTH] ? {1'b1, {(ACC_WIDTH-1){1'b0}}}
                                : {1'b0, {(ACC_WIDTH-1){1'b1}}};
        return s[ACC_WIDTH-1:0];
    endfunction

    function automatic acc_t clampv(input acc_t v, input acc_t lim);
        if (v > lim)
            return lim;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    state_t     state_reg, state_next;
    logic [7:0] ctrl_expect_reg, ctrl_expect_next;
    logic       sys_ok_reg, sys_ok_next;
    logic [7:0] mode_reg, mode_next;
    logic [7:0] port_reg, port_next;
    logic [1:0] pend_reg, pend_next;
    logic [1:0] kexp_reg, kexp_next;
    logic [1:0] scan_set_reg, scan_set_next;
    logic [1:0] aexp_reg, aexp_next;
    logic [7:0] astat_reg, astat_next;
    logic [7:0] ares_reg, ares_next;
    logic [7:0] arate_reg, arate_next;
    logic       wrap_reg, wrap_next;
    logic [2:0] kind_reg, kind_next;
    logic [1:0] detect_reg, detect_next;
    acc_t       ax_reg, ax_next, ay_reg, ay_next, az_reg, az_next;
    logic [2:0] btn_reg, btn_next;
    logic [7:0] buf_reg [4];
    logic [7:0] buf_next [4];
    logic [2:0] buf_n_reg, buf_n_next;
    logic [1:0] idx_reg, idx_next;
    logic       buf_aux_reg, buf_aux_next;
    logic       after_pkt_reg, after_pkt_next;
    logic       in_pkt_reg, in_pkt_next;
    logic       stream_reg, stream_next;
    logic       rd_aux_reg, rd_aux_next;
    logic [7:0] rdata_reg, rdata_next;
    res_t       res_reg, res_next;
    logic       res_valid_reg, res_valid_next;

    fifo_ctl_t     kf_ctl, af_ctl;
    logic [7:0]    kf_rdata, af_rdata;
    logic [CW-1:0] kf_count, af_count;

    // decisions handed from the datapath to the state logic
    logic go_emit, go_chk, go_rd, emit_last, slot_free, acc_nz;

    ps2kmc_fifo #(.FIFO_DEPTH(FIFO_DEPTH)) u_kbd_fifo
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (kf_ctl),
        .rdata (kf_rdata),
        .count (kf_count)
    );

    ps2kmc_fifo #(.FIFO_DEPTH(FIFO_DEPTH)) u_aux_fifo
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (af_ctl),
        .rdata (af_rdata),
        .count (af_count)
    );

    assign res       = res_reg;
    assign res_valid = res_valid_reg;
    assign head_take = (state_reg == ST_IDLE) && head_valid;
    assign slot_free = !res_valid_reg || res_pop;
    assign emit_last = ({1'b0, idx_reg} == (buf_n_reg - 3'd1));
    assign acc_nz    = (ax_reg != '0) || (ay_reg != '0) || (az_reg != '0);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (head_valid)
                begin
                    priority if (go_rd)
                        state_next = ST_RD_WAIT;
                    else if (go_emit)
                        state_next = ST_EMIT;
                    else if (go_chk)
                        state_next = ST_CHK;
                    else
                        state_next = ST_DONE;
                end
            end
            ST_RD_WAIT: state_next = ST_DONE;
            ST_EMIT:
            begin
                if (emit_last)
                begin
                    priority if (after_pkt_reg)
                        state_next = ST_PKT;
                    else if (in_pkt_reg)
                        state_next = ST_POST;
                    else
                        state_next = ST_DONE;
                end
            end
            ST_CHK:  state_next = (af_count >= CNT_FULL) ? ST_DONE : ST_PKT;
            ST_PKT:  state_next = ST_EMIT;
            ST_POST: state_next = (stream_reg && acc_nz) ? ST_CHK : ST_DONE;
            ST_DONE:
            begin
                if (slot_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        logic [7:0] v;
        logic       xlat;
        logic [1:0] pn;
        acc_t       dx, dy, dz;
        logic [7:0] b0;

        v    = head.wdata;
        xlat = mode_reg[6];
        pn   = pend_reg;
        dx   = clampv(ax_reg, LIM_P);
        dy   = clampv(ay_reg, LIM_P);
        dz   = clampv(az_reg, (kind_reg == KIND_5BTN) ? LIM_Z : LIM_P);
        b0   = {2'b00, dy < 0, dx < 0, 1'b1, btn_reg};

        ctrl_expect_next = ctrl_expect_reg;
        sys_ok_next      = sys_ok_reg;
        mode_next        = mode_reg;
        port_next        = port_reg;
        pend_next        = pend_reg;
        kexp_next        = kexp_reg;
        scan_set_next    = scan_set_reg;
        aexp_next        = aexp_reg;
        astat_next       = astat_reg;
        ares_next        = ares_reg;
        arate_next       = arate_reg;
        wrap_next        = wrap_reg;
        kind_next        = kind_reg;
        detect_next      = detect_reg;
        ax_next          = ax_reg;
        ay_next          = ay_reg;
        az_next          = az_reg;
        btn_next         = btn_reg;
        buf_next         = buf_reg;
        buf_n_next       = buf_n_reg;
        idx_next         = idx_reg;
        buf_aux_next     = buf_aux_reg;
        after_pkt_next   = after_pkt_reg;
        in_pkt_next      = in_pkt_reg;
        stream_next      = stream_reg;
        rd_aux_next      = rd_aux_reg;
        rdata_next       = rdata_reg;
        res_next         = res_reg;
        res_valid_next   = res_valid_reg && !res_pop;
        kf_ctl           = '0;
        af_ctl           = '0;
        go_emit          = 1'b0;
        go_chk           = 1'b0;
        go_rd            = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (head_valid)
                begin
                    rdata_next   = 8'h00;
                    buf_n_next   = 3'd0;
                    buf_aux_next = 1'b0;
                    idx_next     = 2'd0;
                    unique case (head.op)
                        OP_RD:
                        begin
                            go_rd = 1'b1;
                            if (pend_reg == PEND_AUX)
                            begin
                                af_ctl.pop  = 1'b1;
                                rd_aux_next = 1'b1;
                                pn[1]       = (af_count > CW'(1));
                            end
                            else
                            begin
                                kf_ctl.pop  = 1'b1;
                                rd_aux_next = 1'b0;
                                pn[0]       = (kf_count > CW'(1));
                            end
                            pend_next = pn;
                            port_next = refresh_port(port_reg, pn);
                        end
                        OP_STAT:
                            rdata_next = {2'b00, pend_reg == PEND_AUX, 2'b11, sys_ok_reg,
                                          1'b0, pend_reg != 2'd0};
                        OP_WR:
                        begin
                            ctrl_expect_next = CC_NONE;
                            unique case (ctrl_expect_reg)
                                CC_WR_MODE:
                                begin
                                    mode_next = v;
                                    port_next = refresh_port(port_reg, pend_reg);
                                end
                                CC_WR_KOBUF:
                                begin
                                    buf_next[0] = v;
                                    buf_n_next  = 3'd1;
                                end
                                CC_WR_AOBUF:
                                begin
                                    buf_next[0]  = v;
                                    buf_n_next   = 3'd1;
                                    buf_aux_next = 1'b1;
                                end
                                CC_WR_OUT: port_next = v;
                                CC_WR_AUX:
                                begin
                                    buf_aux_next = 1'b1;
                                    aexp_next    = AX_IDLE;
                                    buf_next[0]  = B_ACK;
                                    if (aexp_reg == AX_RES)
                                    begin
                                        ares_next  = v;
                                        buf_n_next = 3'd1;
                                    end
                                    else if (aexp_reg == AX_RATE)
                                    begin
                                        arate_next = v;
                                        buf_n_next = 3'd1;
                                        priority case (detect_reg)
                                            DT_200:
                                                detect_next = (v == RATE_100) ? DT_100 :
                                                              (v == RATE_200) ? DT_2002 :
                                                              DT_IDLE;
                                            DT_100, DT_2002:
                                            begin
                                                if (v == RATE_80)
                                                    kind_next = (detect_reg == DT_100) ?
                                                                KIND_WHEEL : KIND_5BTN;
                                                detect_next = DT_IDLE;
                                            end
                                            default:
                                                if (v == RATE_200)
                                                    detect_next = DT_200;
                                        endcase
                                    end
                                    else if (wrap_reg && v == MC_WRAPOFF)
                                    begin
                                        wrap_next  = 1'b0;
                                        buf_n_next = 3'd1;
                                    end
                                    else if (wrap_reg && v != MC_RESET)
                                    begin
                                        buf_next[0] = v;
                                        buf_n_next  = 3'd1;
                                    end
                                    else
                                    begin
                                        buf_n_next = 3'd1;
                                        unique case (v)
                                            MC_SCALE1: astat_next[4] = 1'b0;
                                            MC_SCALE2: astat_next[4] = 1'b1;
                                            MC_STREAM: astat_next[6] = 1'b0;
                                            MC_WRAPON: wrap_next = 1'b1;
                                            MC_REMOTE: astat_next[6] = 1'b1;
                                            MC_ID:
                                            begin
                                                buf_next[1] = {5'd0, kind_reg};
                                                buf_n_next  = 3'd2;
                                            end
                                            MC_SETRES: aexp_next = AX_RES;
                                            MC_RATE:   aexp_next = AX_RATE;
                                            MC_STATUS:
                                            begin
                                                buf_next[1] = astat_reg;
                                                buf_next[2] = ares_reg;
                                                buf_next[3] = arate_reg;
                                                buf_n_next  = 3'd4;
                                            end
                                            MC_READ:   after_pkt_next = 1'b1;
                                            MC_ENABLE:  astat_next[5] = 1'b1;
                                            MC_DISABLE: astat_next[5] = 1'b0;
                                            MC_DEFAULT:
                                            begin
                                                arate_next = RATE_100;
                                                ares_next  = 8'd2;
                                                astat_next = 8'h00;
                                            end
                                            MC_RESET:
                                            begin
                                                arate_next  = RATE_100;
                                                ares_next   = 8'd2;
                                                astat_next  = 8'h00;
                                                kind_next   = KIND_STD;
                                                buf_next[1] = B_BAT_OK;
                                                buf_next[2] = 8'h00;
                                                buf_n_next  = 3'd3;
                                            end
                                            default: buf_n_next = 3'd0;
                                        endcase
                                    end
                                end
                                default:
                                begin
                                    // keyboard byte
                                    kexp_next   = KX_IDLE;
                                    buf_next[0] = B_ACK;
                                    buf_n_next  = 3'd1;
                                    if (kexp_reg == KX_SET)
                                    begin
                                        if (v == 8'h00)
                                        begin
                                            unique case (scan_set_reg)
                                                2'd1:    buf_next[0] = B_SET1;
                                                2'd2:    buf_next[0] = xlat ? B_ID1_XLAT : B_SET2;
                                                2'd3:    buf_next[0] = xlat ? B_SET3_X : B_SET3;
                                                default: buf_n_next = 3'd0;
                                            endcase
                                        end
                                        else if (v >= 8'd1 && v <= 8'd3)
                                            scan_set_next = v[1:0];
                                    end
                                    else if (kexp_reg == KX_IDLE)
                                    begin
                                        unique case (v)
                                            KC_BAD:  buf_next[0] = B_RESEND;
                                            KC_ID:
                                            begin
                                                buf_next[1] = B_ID0;
                                                buf_next[2] = xlat ? B_ID1_XLAT : B_ID1;
                                                buf_n_next  = 3'd3;
                                            end
                                            KC_ECHO:    buf_next[0] = KC_ECHO;
                                            KC_SCANSET: kexp_next = KX_SET;
                                            KC_LEDS:    kexp_next = KX_LEDS;
                                            KC_RATE:    kexp_next = KX_RATE;
                                            KC_DISABLE, KC_DEFAULT: scan_set_next = 2'd2;
                                            KC_RESET:
                                            begin
                                                scan_set_next = 2'd2;
                                                buf_next[1]   = B_BAT_OK;
                                                buf_n_next    = 3'd2;
                                            end
                                            default: buf_n_next = 3'd1;
                                        endcase
                                    end
                                end
                            endcase
                        end
                        OP_CMD:
                        begin
                            buf_next[0] = 8'h00;
                            if (v[7:4] != 4'hF)
                            begin
                                unique case (v)
                                    CC_RD_MODE:
                                    begin
                                        buf_next[0] = mode_reg;
                                        buf_n_next  = 3'd1;
                                    end
                                    CC_WR_MODE, CC_WR_OUT, CC_WR_KOBUF, CC_WR_AOBUF,
                                    CC_WR_AUX:
                                        ctrl_expect_next = v;
                                    CC_AUX_DIS: mode_next[5] = 1'b1;
                                    CC_AUX_EN:  mode_next[5] = 1'b0;
                                    CC_AUX_TEST, CC_KBD_TEST, CC_RD_IN: buf_n_next = 3'd1;
                                    CC_SELFTEST:
                                    begin
                                        sys_ok_next = 1'b1;
                                        buf_next[0] = B_SELFTEST;
                                        buf_n_next  = 3'd1;
                                    end
                                    CC_KBD_DIS:
                                    begin
                                        mode_next[4] = 1'b1;
                                        port_next    = refresh_port(port_reg, pend_reg);
                                    end
                                    CC_KBD_EN:
                                    begin
                                        mode_next[4] = 1'b0;
                                        port_next    = refresh_port(port_reg, pend_reg);
                                    end
                                    CC_RD_OUT:
                                    begin
                                        buf_next[0] = port_reg;
                                        buf_n_next  = 3'd1;
                                    end
                                    CC_A20_ON:  port_next[1] = 1'b1;
                                    CC_A20_OFF: port_next[1] = 1'b0;
                                    default:    buf_n_next = 3'd0;
                                endcase
                            end
                        end
                        OP_EVT:
                        begin
                            if (astat_reg[5])
                            begin
                                ax_next  = sat_add(ax_reg, head.mx, 1'b0);
                                ay_next  = sat_add(ay_reg, head.my, 1'b1);
                                az_next  = sat_add(az_reg, head.mz, 1'b0);
                                btn_next = head.btn;
                                if (!astat_reg[6] && af_count < CNT_HIGH)
                                begin
                                    stream_next = 1'b1;
                                    go_chk      = 1'b1;
                                end
                            end
                        end
                        default: rdata_next = 8'h00;
                    endcase
                    go_emit = (buf_n_next != 3'd0) && !go_rd;
                end
            end
            ST_RD_WAIT:
                rdata_next = rd_aux_reg ? af_rdata : kf_rdata;
            ST_EMIT:
            begin
                if (buf_aux_reg)
                begin
                    af_ctl.push = 1'b1;
                    af_ctl.data = buf_reg[idx_reg];
                    pn          = pend_reg | 2'b10;
                end
                else
                begin
                    kf_ctl.push = 1'b1;
                    kf_ctl.data = buf_reg[idx_reg];
                    pn          = pend_reg | 2'b01;
                end
                pend_next = pn;
                port_next = refresh_port(port_reg, pn);
                idx_next  = emit_last ? 2'd0 : idx_reg + 2'd1;
                if (emit_last && after_pkt_reg)
                    after_pkt_next = 1'b0;
            end
            ST_CHK:
            begin
                if (af_count >= CNT_FULL)
                begin
                    ax_next = '0;
                    ay_next = '0;
                    az_next = '0;
                end
            end
            ST_PKT:
            begin
                buf_next[0]  = b0;
                buf_next[1]  = dx[7:0];
                buf_next[2]  = dy[7:0];
                buf_next[3]  = dz[7:0];
                buf_aux_next = 1'b1;
                idx_next     = 2'd0;
                in_pkt_next  = 1'b1;
                ax_next      = ax_reg - dx;
                ay_next      = ay_reg - dy;
                if (kind_reg == KIND_WHEEL || kind_reg == KIND_5BTN)
                begin
                    buf_n_next = 3'd4;
                    az_next    = az_reg - dz;
                end
                else
                begin
                    buf_n_next = 3'd3;
                    az_next    = '0;
                end
            end
            ST_POST:
                in_pkt_next = 1'b0;
            ST_DONE:
            begin
                if (slot_free)
                begin
                    res_next.rdata   = rdata_reg;
                    res_next.kbd_irq = (pend_reg != 2'd0) && (pend_reg != PEND_AUX) &&
                                       mode_reg[0] && !mode_reg[4];
                    res_next.aux_irq = (pend_reg == PEND_AUX) && mode_reg[1];
                    res_next.a20     = port_reg[1];
                    res_valid_next   = 1'b1;
                    stream_next      = 1'b0;
                end
            end
            default: res_valid_next = res_valid_reg && !res_pop;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            ctrl_expect_reg <= CC_NONE;
            sys_ok_reg      <= 1'b0;
            mode_reg        <= 8'h03;
            port_reg        <= 8'h03;
            pend_reg        <= 2'd0;
            kexp_reg        <= KX_IDLE;
            scan_set_reg    <= 2'd2;
            aexp_reg        <= AX_IDLE;
            astat_reg       <= 8'h00;
            ares_reg        <= 8'h00;
            arate_reg       <= 8'h00;
            wrap_reg        <= 1'b0;
            kind_reg        <= KIND_STD;
            detect_reg      <= DT_IDLE;
            ax_reg          <= '0;
            ay_reg          <= '0;
            az_reg          <= '0;
            btn_reg         <= 3'd0;
            buf_n_reg       <= 3'd0;
            idx_reg         <= 2'd0;
            buf_aux_reg     <= 1'b0;
            after_pkt_reg   <= 1'b0;
            in_pkt_reg      <= 1'b0;
            stream_reg      <= 1'b0;
            rd_aux_reg      <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            ctrl_expect_reg <= ctrl_expect_next;
            sys_ok_reg      <= sys_ok_next;
            mode_reg        <= mode_next;
            port_reg        <= port_next;
            pend_reg        <= pend_next;
            kexp_reg        <= kexp_next;
            scan_set_reg    <= scan_set_next;
            aexp_reg        <= aexp_next;
            astat_reg       <= astat_next;
            ares_reg        <= ares_next;
            arate_reg       <= arate_next;
            wrap_reg        <= wrap_next;
            kind_reg        <= kind_next;
            detect_reg      <= detect_next;
            ax_reg          <= ax_next;
            ay_reg          <= ay_next;
            az_reg          <= az_next;
            btn_reg         <= btn_next;
            buf_n_reg       <= buf_n_next;
            idx_reg         <= idx_next;
            buf_aux_reg     <= buf_aux_next;
            after_pkt_reg   <= after_pkt_next;
            in_pkt_reg      <= in_pkt_next;
            stream_reg      <= stream_next;
            rd_aux_reg      <= rd_aux_next;
            res_valid_reg   <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg   <= buf_next;
        rdata_reg <= rdata_next;
        res_reg   <= res_next;
    end

    `PS2KMC_ASSERT_NEXT(a_done_fills, clk, rst_n, state_reg == ST_DONE && !res_valid_reg, res_valid_reg, "finished beat not presented")
    `PS2KMC_ASSERT_NOW(a_emit_idx, clk, rst_n, state_reg == ST_EMIT, buf_n_reg != 3'd0 && {1'b0, idx_reg} < buf_n_reg, "reply index out of range")
    `PS2KMC_ASSERT_NOW(a_one_push, clk, rst_n, 1'b1, !(kf_ctl.push && af_ctl.push) && !(kf_ctl.pop && af_ctl.pop), "both queues touched at once")

endmodule

`default_nettype wire

// File: hdl/ps2_keyboard_mouse_controller.sv
// ----------------------------------------------------------------------------
// ps2_keyboard_mouse_controller
// 8042-style keyboard and mouse controller behind queue-style port channels.
//
//   channel  | handshake           | beat
//   ---------+---------------------+------------------------------------------
//   input    | push / full         | func, wdata, move_x/y/z, btn_left/middle/right
//   result   | empty / pop         | rdata, kbd_irq, aux_irq, a20_gate
//
// a status read or an access with no reply goes straight to the result, a data read
// pops one reply queue first, a command with replies pushes its reply bytes into a queue;
// a mouse read command pushes a packet after its acknowledge byte.
// a mouse event streams 3-byte or 4-byte packets, one byte per cycle through the
// single write port of the mouse queue.
// reset is asynchronous and needs no clearing pass; queue entries start unset.
// two input beats can wait ahead of the back end while a result waits for pop.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2_keyboard_mouse_controller
    import ps2kmc_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF,
    parameter int ACC_WIDTH  = ACC_WIDTH_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [2:0]  func,
    input  wire logic [7:0]  wdata,
    input  wire logic [11:0] move_x,
    input  wire logic [11:0] move_y,
    input  wire logic [11:0] move_z,
    input  wire logic        btn_left,
    input  wire logic        btn_middle,
    input  wire logic        btn_right,
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       rdata,
    output logic             kbd_irq,
    output logic             aux_irq,
    output logic             a20_gate
);

    item_t head;
    logic  head_valid, head_take, res_valid;
    res_t  res;

    ps2kmc_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .func       (func),
        .wdata      (wdata),
        .move_x     (move_x),
        .move_y     (move_y),
        .move_z     (move_z),
        .btn_left   (btn_left),
        .btn_middle (btn_middle),
        .btn_right  (btn_right),
        .head       (head),
        .head_valid (head_valid),
        .head_take  (head_take)
    );

    ps2kmc_engine #(.FIFO_DEPTH(FIFO_DEPTH), .ACC_WIDTH(ACC_WIDTH)) u_engine
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .head_take  (head_take),
        .res        (res),
        .res_valid  (res_valid),
        .res_pop    (pop)
    );

    assign empty    = !res_valid;
    assign rdata    = res.rdata;
    assign kbd_irq  = res.kbd_irq;
    assign aux_irq  = res.aux_irq;
    assign a20_gate = res.a20;

endmodule

`default_nettype wire
